@@ sv/lifeg_pkg.sv @@
package lifeg_pkg;

   // Grid size
   localparam int GRID_COLS = 64;
   localparam int GRID_ROWS = 64;

   // Coordinate fields on the request side
   localparam int COORD_W   = 8;
   localparam int ROW_IDX_W = $clog2(GRID_ROWS);
   localparam int COL_CNT_W = $clog2(GRID_COLS);

   // Rule B3/S23 neighbor counts
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef logic [GRID_ROWS-1:0] column_type;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_INVERT = 2'd1,
      OP_READ   = 2'd2,
      OP_STEP   = 2'd3
   } op_type;

   // Cell operation broadcast from the top level to every column cell
   typedef struct packed {
      logic                 valid;
      op_type               op;
      logic [COORD_W-1:0]   col_x;
      logic [ROW_IDX_W-1:0] row_idx;
      logic                 write_value;
   } cell_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CELL = 3'b010,
      ST_STEP = 3'b100
   } state_type;

endpackage

@@ sv/life_automaton_grid_top.sv @@
// Game of Life grid, rule B3/S23, on a bounded grid that does not wrap.
// Request channel: a transaction is taken at a rising edge with start high
// and busy low; req_op selects write, invert, read or advance-one-generation,
// req_col_x / req_row_y address the cell, req_write_value is the write data.
// Result channel: rsp_valid is high for exactly one cycle per transaction,
// carrying rsp_cell_value (cell state after the operation) and
// rsp_range_error (coordinates outside the grid, grid left untouched).
// The receiver cannot stall; each result is taken in its strobe cycle.
// Cell operations pass through ST_CELL, and the result is registered as
// the block returns to idle. A generation step holds ST_STEP while the
// column chain rotates once through the single next-state rule unit.
// A new request may be taken in the cycle its predecessor's result shows.
// Reset clears every cell to dead and drops any transaction in flight;
// the block is ready in the first cycle after reset.
module life_automaton_grid_top
   import lifeg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic [COORD_W-1:0] req_col_x,
   input  logic [COORD_W-1:0] req_row_y,
   input  logic               req_write_value,
   output logic               rsp_valid,
   output logic               rsp_cell_value,
   output logic               rsp_range_error
);

   state_type              state_ff, state_in;
   logic [COL_CNT_W-1:0]   step_cnt_ff, step_cnt_in;
   column_type             left_ff, left_in;
   logic                   err_ff, err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_value_ff, rsp_value_in;
   logic                   rsp_err_ff, rsp_err_in;

   logic                   accept;
   logic                   in_range;
   logic                   shift_en;
   logic                   last_col;
   op_type                 req_op_e;
   cell_cmd_type           cmd;
   column_type             cols [GRID_COLS];
   logic [GRID_COLS-1:0]   taps;
   column_type             right_col;
   column_type             next_col;

   assign req_op_e = op_type'(req_op);
   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign in_range = ({1'b0, req_col_x} < 9'(GRID_COLS)) &&
                     (req_row_y < COORD_W'(GRID_ROWS));

   // Broadcast a cell operation to the chain
   always_comb begin
      cmd.valid       = accept && (req_op_e != OP_STEP) && in_range;
      cmd.op          = req_op_e;
      cmd.col_x       = req_col_x;
      cmd.row_idx     = req_row_y[ROW_IDX_W-1:0];
      cmd.write_value = req_write_value;
   end

   assign shift_en  = (state_ff == ST_STEP);
   assign last_col  = (step_cnt_ff == COL_CNT_W'(GRID_COLS - 1));
   assign right_col = last_col ? '0 : cols[1];

   // Column chain: the head holds the column being judged
   for (genvar k = 0; k < GRID_COLS; k++) begin : g_col
      column_type nbr_col;
      if (k == GRID_COLS - 1) begin : g_tail
         assign nbr_col = next_col;
      end else begin : g_mid
         assign nbr_col = cols[k+1];
      end
      lifeg_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_id  (COORD_W'(k)),
         .cmd      (cmd),
         .shift_en (shift_en),
         .shift_in (nbr_col),
         .column   (cols[k]),
         .tap      (taps[k])
      );
   end

   lifeg_rule u_rule (
      .left_col  (left_ff),
      .mid_col   (cols[0]),
      .right_col (right_col),
      .next_col  (next_col)
   );

   // Sequence cell operations and generation sweeps
   always_comb begin
      state_in     = state_ff;
      step_cnt_in  = step_cnt_ff;
      left_in      = left_ff;
      err_in       = err_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op_e == OP_STEP) begin
                  state_in    = ST_STEP;
                  step_cnt_in = '0;
                  left_in     = '0;
               end else begin
                  state_in = ST_CELL;
                  err_in   = !in_range;
               end
            end
         end
         ST_CELL: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_value_in = |taps;
            rsp_err_in   = err_ff;
         end
         ST_STEP: begin
            left_in     = cols[0];
            step_cnt_in = step_cnt_ff + 1'b1;
            if (last_col) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_value_in = 1'b0;
               rsp_err_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_cnt_ff  <= step_cnt_in;
      left_ff      <= left_in;
      err_ff       <= err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_value  = rsp_value_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule

@@ sv/lifeg_cell.sv @@
module lifeg_cell
   import lifeg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [COORD_W-1:0] cell_id,
   input  cell_cmd_type       cmd,
   input  logic               shift_en,
   input  column_type         shift_in,
   output column_type         column,
   output logic               tap
);

   column_type col_ff, col_in;
   logic       tap_ff, tap_in;
   logic       hit;

   assign hit = cmd.valid && (cmd.col_x == cell_id);

   // Take the neighbor's column while shifting, else apply a cell operation
   always_comb begin
      col_in = col_ff;
      if (shift_en) begin
         col_in = shift_in;
      end else if (hit) begin
         case (cmd.op)
            OP_WRITE:  col_in[cmd.row_idx] = cmd.write_value;
            OP_INVERT: col_in[cmd.row_idx] = ~col_ff[cmd.row_idx];
            default:   col_in = col_ff;
         endcase
      end
   end

   // Present the addressed bit after the operation, zero when not addressed
   assign tap_in = hit ? col_in[cmd.row_idx] : 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.valid || (cmd.op != OP_STEP)) begin
         tap_ff <= tap_in;
      end
   end

   assign column = col_ff;
   assign tap    = tap_ff;

endmodule

@@ sv/lifeg_rule.sv @@
module lifeg_rule
   import lifeg_pkg::*;
(
   input  column_type left_col,
   input  column_type mid_col,
   input  column_type right_col,
   output column_type next_col
);

   logic [GRID_ROWS+1:0] left_ext, mid_ext, right_ext;

   // Pad with dead cells above and below the grid
   assign left_ext  = {1'b0, left_col, 1'b0};
   assign mid_ext   = {1'b0, mid_col, 1'b0};
   assign right_ext = {1'b0, right_col, 1'b0};

   // Count eight neighbors per row and apply B3/S23
   always_comb begin
      logic [3:0] count;
      next_col = '0;
      for (int y = 0; y < GRID_ROWS; y++) begin
         count = 4'(left_ext[y]) + 4'(left_ext[y+1]) + 4'(left_ext[y+2])
               + 4'(right_ext[y]) + 4'(right_ext[y+1]) + 4'(right_ext[y+2])
               + 4'(mid_ext[y]) + 4'(mid_ext[y+2]);
         if (mid_col[y]) begin
            next_col[y] = (count == SURVIVE_COUNT) || (count == BIRTH_COUNT);
         end else begin
            next_col[y] = (count == BIRTH_COUNT);
         end
      end
   end

endmodule

@@ sv/lifeg_checker.sv @@
module lifeg_checker
   import lifeg_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_cell_value,
   input logic rsp_range_error
);

   // An accepted transaction holds the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   // A finished transaction shows its result as busy drops
   a_fall_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // Results never come from an idle block
   a_result_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a transaction in flight");

   // Results are never back to back
   a_result_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   // A rejected coordinate reports a dead cell
   a_err_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> !rsp_cell_value)
      else $error("range error with a live cell value");

endmodule

bind life_automaton_grid_top lifeg_checker u_lifeg_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_cell_value  (rsp_cell_value),
   .rsp_range_error (rsp_range_error)
);

@@ sim/tb_life_automaton_grid_top.sv @@
module tb_life_automaton_grid_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lifeg_pkg::*;

   typedef struct packed {
      logic cell_value;
      logic range_error;
   } cell_result_type;

   // One directed transaction; the expected result is typed in when fixed is set
   typedef struct packed {
      op_type             op;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               wv;
      logic               fixed;
      logic               exp_cell;
      logic               exp_err;
   } grid_stim_type;

   localparam int DIRECTED_COUNT = 25;
   localparam int RANDOM_ITEMS   = 1420;
   localparam int MAX_GAP        = 13;
   localparam int DRAIN_CYCLES   = 80;

   localparam grid_stim_type DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
      // fresh grid reads dead at both corners
      '{OP_READ,   8'd0,   8'd0,   1'b0, 1'b1, 1'b0, 1'b0},
      '{OP_READ,   8'd63,  8'd63,  1'b0, 1'b1, 1'b0, 1'b0},
      // corners of the grid
      '{OP_WRITE,  8'd0,   8'd0,   1'b1, 1'b1, 1'b1, 1'b0},
      '{OP_WRITE,  8'd63,  8'd63,  1'b1, 1'b1, 1'b1, 1'b0},
      '{OP_WRITE,  8'd63,  8'd0,   1'b1, 1'b0, 1'b0, 1'b0},
      '{OP_WRITE,  8'd0,   8'd63,  1'b1, 1'b0, 1'b0, 1'b0},
      '{OP_INVERT, 8'd63,  8'd63,  1'b1, 1'b1, 1'b0, 1'b0},
      // coordinates outside the grid
      '{OP_WRITE,  8'd64,  8'd0,   1'b1, 1'b1, 1'b0, 1'b1},
      '{OP_READ,   8'd0,   8'd64,  1'b0, 1'b1, 1'b0, 1'b1},
      '{OP_INVERT, 8'd255, 8'd255, 1'b1, 1'b1, 1'b0, 1'b1},
      '{OP_WRITE,  8'd128, 8'd5,   1'b1, 1'b1, 1'b0, 1'b1},
      '{OP_READ,   8'd5,   8'd128, 1'b1, 1'b1, 1'b0, 1'b1},
      // generation steps ignore the cell fields
      '{OP_STEP,   8'd0,   8'd0,   1'b0, 1'b1, 1'b0, 1'b0},
      '{OP_STEP,   8'd255, 8'd255, 1'b1, 1'b1, 1'b0, 1'b0},
      '{OP_READ,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0},
      // blinker against the top edge
      '{OP_WRITE,  8'd10,  8'd0,   1'b1, 1'b0, 1'b0, 1'b0},
      '{OP_WRITE,  8'd11,  8'd0,   1'b1, 1'b0, 1'b0, 1'b0},
      '{OP_WRITE,  8'd12,  8'd0,   1'b1, 1'b0, 1'b0, 1'b0},
      '{OP_STEP,   8'd0,   8'd0,   1'b0, 1'b1, 1'b0, 1'b0},
      '{OP_READ,   8'd11,  8'd1,   1'b0, 1'b0, 1'b0, 1'b0},
      // write of a dead cell, then invert with the value bit ignored
      '{OP_WRITE,  8'd0,   8'd5,   1'b0, 1'b1, 1'b0, 1'b0},
      '{OP_INVERT, 8'd0,   8'd5,   1'b0, 1'b0, 1'b0, 1'b0},
      '{OP_READ,   8'd63,  8'd0,   1'b1, 1'b0, 1'b0, 1'b0},
      '{OP_STEP,   8'd127, 8'd64,  1'b0, 1'b1, 1'b0, 1'b0},
      '{OP_READ,   8'd11,  8'd0,   1'b0, 1'b0, 1'b0, 1'b0}
   };

   logic               clock;
   logic               reset           = 1'b1;
   logic               start           = 1'b0;
   logic               busy;
   logic [1:0]         req_op          = OP_READ;
   logic [COORD_W-1:0] req_col_x       = '0;
   logic [COORD_W-1:0] req_row_y       = '0;
   logic               req_write_value = 1'b0;
   logic               rsp_valid;
   logic               rsp_cell_value;
   logic               rsp_range_error;

   column_type      life_grid [GRID_COLS] = '{default: '0};
   cell_result_type pending_results [$];
   cell_result_type oldest_result;
   int              mismatch_count = 0;

   life_automaton_grid_top DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_col_x       (req_col_x),
      .req_row_y       (req_row_y),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_cell_value  (rsp_cell_value),
      .rsp_range_error (rsp_range_error)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Advance the whole grid one B3/S23 generation, every cell judged on the old one
   function automatic void advance_life_grid();
      column_type old_grid [GRID_COLS];
      int         nx;
      int         ny;
      int         neighbors;
      old_grid = life_grid;
      for (int x = 0; x < GRID_COLS; x++) begin
         for (int y = 0; y < GRID_ROWS; y++) begin
            neighbors = 0;
            for (int dx = -1; dx <= 1; dx++) begin
               for (int dy = -1; dy <= 1; dy++) begin
                  nx = x + dx;
                  ny = y + dy;
                  // cells beyond the border count as dead
                  if ((dx != 0 || dy != 0) && nx >= 0 && nx < GRID_COLS &&
                      ny >= 0 && ny < GRID_ROWS)
                     neighbors += old_grid[nx][ny];
               end
            end
            if (old_grid[x][y])
               life_grid[x][y] = (neighbors == SURVIVE_COUNT) || (neighbors == BIRTH_COUNT);
            else
               life_grid[x][y] = (neighbors == BIRTH_COUNT);
         end
      end
   endfunction

   // Apply one transaction to the grid copy and return the cell result it yields
   function automatic cell_result_type apply_grid_request(op_type op,
                                                          logic [COORD_W-1:0] x,
                                                          logic [COORD_W-1:0] y, logic wv);
      cell_result_type res;
      res = '0;
      if (op == OP_STEP) begin
         advance_life_grid();
      end else if (x >= GRID_COLS || y >= GRID_ROWS) begin
         res.range_error = 1'b1;
      end else begin
         case (op)
            OP_WRITE:  life_grid[x][y] = wv;
            OP_INVERT: life_grid[x][y] = ~life_grid[x][y];
            default:   ;
         endcase
         res.cell_value = life_grid[x][y];
      end
      return res;
   endfunction

   // Drive one transaction, hold until taken, then queue its expected result
   task automatic issue_request(input op_type op, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y, input logic wv,
                                input int gap, input bit drain_first,
                                input bit fixed, input cell_result_type fixed_result);
      cell_result_type model_result;
      if (gap > 0 || drain_first) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         if (drain_first) begin
            @(posedge clock);
            while (pending_results.size() != 0) @(posedge clock);
         end
      end
      start           <= 1'b1;
      req_op          <= op;
      req_col_x       <= x;
      req_row_y       <= y;
      req_write_value <= wv;
      @(posedge clock);
      while (busy) @(posedge clock);
      model_result = apply_grid_request(op, x, y, wv);
      pending_results.push_back(fixed ? fixed_result : model_result);
   endtask

   // Check every result strobe against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got cell_value=%0b range_error=%0b",
                     $time, rsp_cell_value, rsp_range_error);
            mismatch_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_cell_value !== oldest_result.cell_value) begin
               $display("%0t: cell_value mismatch, expected %0b, got %0b",
                        $time, oldest_result.cell_value, rsp_cell_value);
               mismatch_count++;
            end
            if (rsp_range_error !== oldest_result.range_error) begin
               $display("%0t: range_error mismatch, expected %0b, got %0b",
                        $time, oldest_result.range_error, rsp_range_error);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #6_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int              sent;
      int              base_x;
      int              base_y;
      int              span;
      int              burst_len;
      int              cx;
      int              cy;
      bit              gaps_on;
      op_type          op;
      cell_result_type typed;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (DIRECTED_ROWS[i]) begin
         typed.cell_value  = DIRECTED_ROWS[i].exp_cell;
         typed.range_error = DIRECTED_ROWS[i].exp_err;
         issue_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].col, DIRECTED_ROWS[i].row,
                       DIRECTED_ROWS[i].wv, $urandom_range(0, MAX_GAP), 1'b0,
                       DIRECTED_ROWS[i].fixed, typed);
      end

      // Random bursts: mostly seeded patches that then evolve, some noise
      sent = 0;
      typed = '0;
      while (sent < RANDOM_ITEMS) begin
         gaps_on = ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 9) < 7) begin
            base_x = $urandom_range(0, GRID_COLS - 1);
            base_y = $urandom_range(0, GRID_ROWS - 1);
            span   = $urandom_range(3, 8);
            // seed the patch, clamped onto the border where it runs over
            burst_len = $urandom_range(4, 16);
            for (int k = 0; k < burst_len; k++) begin
               cx = base_x + $urandom_range(0, span - 1);
               cy = base_y + $urandom_range(0, span - 1);
               if (cx > GRID_COLS - 1) cx = GRID_COLS - 1;
               if (cy > GRID_ROWS - 1) cy = GRID_ROWS - 1;
               op = ($urandom_range(0, 4) == 0) ? OP_INVERT : OP_WRITE;
               issue_request(op, COORD_W'(cx), COORD_W'(cy), ($urandom_range(0, 2) != 0),
                             gaps_on ? $urandom_range(0, MAX_GAP) : 0,
                             ($urandom_range(0, 59) == 0), 1'b0, typed);
               sent++;
            end
            // let it evolve
            burst_len = $urandom_range(1, 3);
            for (int k = 0; k < burst_len; k++) begin
               issue_request(OP_STEP, COORD_W'($urandom_range(0, 255)),
                             COORD_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             gaps_on ? $urandom_range(0, MAX_GAP) : 0,
                             1'b0, 1'b0, typed);
               sent++;
            end
            // probe the patch and its rim
            burst_len = $urandom_range(2, 6);
            for (int k = 0; k < burst_len; k++) begin
               cx = base_x - 1 + $urandom_range(0, span + 1);
               cy = base_y - 1 + $urandom_range(0, span + 1);
               if (cx < 0) cx = 0;
               if (cy < 0) cy = 0;
               if (cx > GRID_COLS - 1) cx = GRID_COLS - 1;
               if (cy > GRID_ROWS - 1) cy = GRID_ROWS - 1;
               op = ($urandom_range(0, 5) == 0) ? OP_INVERT : OP_READ;
               issue_request(op, COORD_W'(cx), COORD_W'(cy), 1'($urandom_range(0, 1)),
                             gaps_on ? $urandom_range(0, MAX_GAP) : 0, 1'b0, 1'b0, typed);
               sent++;
            end
         end else begin
            // noise: any operation, coordinates often off the grid
            burst_len = $urandom_range(3, 10);
            for (int k = 0; k < burst_len; k++) begin
               op = op_type'($urandom_range(0, 3));
               cx = $urandom_range(0, 1) ? $urandom_range(0, GRID_COLS - 1)
                                         : $urandom_range(0, 255);
               cy = $urandom_range(0, 1) ? $urandom_range(0, GRID_ROWS - 1)
                                         : $urandom_range(0, 255);
               issue_request(op, COORD_W'(cx), COORD_W'(cy), 1'($urandom_range(0, 1)),
                             gaps_on ? $urandom_range(0, MAX_GAP) : 0,
                             ($urandom_range(0, 39) == 0), 1'b0, typed);
               sent++;
            end
         end
      end

      // Drop start, drain what is pending, then watch for strays
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
